FILE: rtl/asf_packet_header_parser_defines.svh
// assertion macros used by the header parser checker
`ifndef ASF_PACKET_HEADER_PARSER_DEFINES_SVH
`define ASF_PACKET_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ASFPH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("asfph assertion failed");

// next-cycle implication, disabled while reset is low
`define ASFPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("asfph assertion failed");

`endif

FILE: rtl/asfph_pkg.sv
// types, constants and helper functions of the asf header parser
package asfph_pkg;

  // parse phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_EC      = 5'd1,
    PH_FLAGS   = 5'd2,
    PH_PROP    = 5'd3,
    PH_PLEN    = 5'd4,
    PH_SEQ     = 5'd5,
    PH_PAD     = 5'd6,
    PH_STIME   = 5'd7,
    PH_DUR     = 5'd8,
    PH_PCOUNT  = 5'd9,
    PH_PFLAGS  = 5'd10,
    PH_MOBJ    = 5'd11,
    PH_MOFF    = 5'd12,
    PH_REPLEN  = 5'd13,
    PH_REPSKIP = 5'd14,
    PH_PAYLEN  = 5'd15,
    PH_PAYSKIP = 5'd16,
    PH_DONE    = 5'd17
  } phase_e;

  localparam logic [7:0] LeadByte    = 8'h82;
  localparam logic [3:0] EcNibble    = 4'h2;
  localparam logic [5:0] CountMask   = 6'h3f;
  localparam logic [5:0] SinglePay   = 6'd1;

  // request held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       start_of_packet;
  } in_req_t;

  // finished result of one packet
  typedef struct packed {
    logic [31:0] send_time;
    logic [15:0] duration;
    logic        key_frame;
    logic        header_bad;
  } result_t;

  // parser to result register
  typedef struct packed {
    logic    done;
    result_t res;
  } res_req_t;

  // size code: 0, 1, 2 or 4 bytes
  function automatic logic [2:0] code_bytes(logic [1:0] code);
    code_bytes = (code == 2'd3) ? 3'd4 : {1'b0, code};
  endfunction

  // bytes in the field of a phase
  function automatic logic [2:0] bytes_needed(phase_e ph, logic [7:0] pfb);
    logic [2:0] n;
    unique case (ph)
      PH_EC:     n = 3'd2;
      PH_PLEN:   n = code_bytes(pfb[6:5]);
      PH_SEQ:    n = code_bytes(pfb[2:1]);
      PH_PAD:    n = code_bytes(pfb[4:3]);
      PH_STIME:  n = 3'd4;
      PH_MOFF:   n = 3'd4;
      PH_DUR:    n = 3'd2;
      PH_PAYLEN: n = 3'd2;
      default:   n = 3'd1;
    endcase
    bytes_needed = n;
  endfunction

  // phase to enter, passing over zero-size length, sequence and padding fields
  function automatic phase_e enter_phase(phase_e ph, logic [7:0] pfb);
    phase_e p;
    p = ph;
    if (p == PH_PLEN && pfb[6:5] == 2'b00) p = PH_SEQ;
    if (p == PH_SEQ && pfb[2:1] == 2'b00) p = PH_PAD;
    if (p == PH_PAD && pfb[4:3] == 2'b00) p = PH_STIME;
    enter_phase = p;
  endfunction

endpackage

FILE: rtl/asf_packet_header_parser.sv
// top level of the asf data packet header parser
// Takes one packet byte per cycle unless stalled and emits at most one request per packet,
// on the byte that ends the parse: keyframe found, payload count exhausted, or empty payload
// list. Each byte goes through an input register, one pass of parse logic, and a result
// register; a result enters the result register as its last byte leaves the input register.
// Stall on the output holds the result register; the input stalls only while that register
// is full and held. video_stream may be written at any time the block is idle.
module asf_packet_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [6:0]  cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_data_byte_i,
  input  logic        in_start_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_send_time_o,
  output logic [15:0] out_duration_o,
  output logic        out_key_frame_o,
  output logic        out_header_bad_o
);

  asfph_pkg::in_req_t  in_req;
  asfph_pkg::res_req_t res_req;
  logic                out_ready;

  // input register
  asfph_in_stage u_in (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_data_byte_i       (in_data_byte_i),
    .in_start_of_packet_i (in_start_of_packet_i),
    .consume_i            (out_ready),
    .req_o                (in_req)
  );

  // parse state and logic
  asfph_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .req_i         (in_req),
    .advance_i     (out_ready),
    .res_o         (res_req)
  );

  // result register
  asfph_out_stage u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_i            (res_req),
    .ready_o          (out_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_send_time_o  (out_send_time_o),
    .out_duration_o   (out_duration_o),
    .out_key_frame_o  (out_key_frame_o),
    .out_header_bad_o (out_header_bad_o)
  );

endmodule

FILE: rtl/asfph_in_stage.sv
// input register for incoming byte requests
module asfph_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_data_byte_i,
  input  logic                in_start_of_packet_i,
  input  logic                consume_i,
  output asfph_pkg::in_req_t  req_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       sop_q;

  // hold while the held request cannot move on
  assign in_stall_o = valid_q & ~consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_data_byte_i;
      sop_q  <= in_start_of_packet_i;
    end
  end

  assign req_o = '{valid: valid_q, data_byte: byte_q, start_of_packet: sop_q};

endmodule

FILE: rtl/asfph_parser.sv
// parse state and per-byte next-state logic
module asfph_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [6:0]          cfg_wr_data_i,
  input  asfph_pkg::in_req_t  req_i,
  input  logic                advance_i,
  output asfph_pkg::res_req_t res_o
);

  asfph_pkg::phase_e phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] skip_q, skip_d;
  logic [5:0]  pl_q, pl_d;
  logic [7:0]  pfb_q, pfb_d;
  logic [7:0]  cpf_q, cpf_d;
  logic [31:0] stime_q, stime_d;
  logic [15:0] dur_q, dur_d;
  logic        err_q, err_d;
  logic        key_q, key_d;
  logic [6:0]  vstream_q;

  logic        step;
  logic [7:0]  b;
  logic [31:0] acc_new;
  logic [2:0]  cnt_new;
  logic        field_complete;
  logic        key_hit;
  logic [5:0]  pl_dec;
  logic [15:0] skip_dec;

  assign step = req_i.valid & advance_i;
  assign b    = req_i.data_byte;

  // shared datapath terms
  assign acc_new        = acc_q | ({24'd0, b} << {cnt_q[1:0], 3'b000});
  assign cnt_new        = cnt_q + 3'd1;
  assign field_complete = cnt_new >= asfph_pkg::bytes_needed(phase_q, pfb_q);
  assign key_hit        = (cpf_q[6:0] == vstream_q) && cpf_q[7] && (acc_new == 32'd0);
  assign pl_dec         = (pl_q - 6'd1) & asfph_pkg::CountMask;
  assign skip_dec       = skip_q - 16'd1;

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    skip_d  = skip_q;
    pl_d    = pl_q;
    pfb_d   = pfb_q;
    cpf_d   = cpf_q;
    stime_d = stime_q;
    dur_d   = dur_q;
    err_d   = err_q;
    key_d   = key_q;
    if (step) begin
      if (req_i.start_of_packet) begin
        // new packet, abandon anything unfinished
        err_d   = (b != asfph_pkg::LeadByte);
        key_d   = 1'b0;
        pfb_d   = 8'd0;
        cpf_d   = 8'd0;
        pl_d    = 6'd0;
        skip_d  = 16'd0;
        stime_d = 32'd0;
        dur_d   = 16'd0;
        cnt_d   = 3'd0;
        acc_d   = 32'd0;
        phase_d = (b[3:0] == asfph_pkg::EcNibble) ? asfph_pkg::PH_EC : asfph_pkg::PH_FLAGS;
      end else begin
        unique case (phase_q)
          asfph_pkg::PH_IDLE, asfph_pkg::PH_DONE: begin
          end
          asfph_pkg::PH_REPSKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_d = asfph_pkg::PH_PAYLEN;
              cnt_d   = 3'd0;
              acc_d   = 32'd0;
            end
          end
          asfph_pkg::PH_PAYSKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 16'd0) begin
              pl_d = pl_dec;
              if (pl_dec != 6'd0) begin
                phase_d = asfph_pkg::PH_PFLAGS;
                cnt_d   = 3'd0;
                acc_d   = 32'd0;
              end else begin
                phase_d = asfph_pkg::PH_DONE;
              end
            end
          end
          asfph_pkg::PH_EC, asfph_pkg::PH_FLAGS, asfph_pkg::PH_PROP,
          asfph_pkg::PH_PLEN, asfph_pkg::PH_SEQ, asfph_pkg::PH_PAD,
          asfph_pkg::PH_STIME, asfph_pkg::PH_DUR, asfph_pkg::PH_PCOUNT,
          asfph_pkg::PH_PFLAGS, asfph_pkg::PH_MOBJ, asfph_pkg::PH_MOFF,
          asfph_pkg::PH_REPLEN, asfph_pkg::PH_PAYLEN: begin
            acc_d = acc_new;
            cnt_d = cnt_new;
            if (field_complete) begin
              // field finished, most arms open the next field
              cnt_d = 3'd0;
              acc_d = 32'd0;
              case (phase_q)
                asfph_pkg::PH_EC: begin
                  if (acc_new != 32'd0) err_d = 1'b1;
                  phase_d = asfph_pkg::PH_FLAGS;
                end
                asfph_pkg::PH_FLAGS: begin
                  pfb_d   = acc_new[7:0];
                  phase_d = asfph_pkg::PH_PROP;
                end
                asfph_pkg::PH_PROP:
                  phase_d = asfph_pkg::enter_phase(asfph_pkg::PH_PLEN, pfb_q);
                asfph_pkg::PH_PLEN:
                  phase_d = asfph_pkg::enter_phase(asfph_pkg::PH_SEQ, pfb_q);
                asfph_pkg::PH_SEQ:
                  phase_d = asfph_pkg::enter_phase(asfph_pkg::PH_PAD, pfb_q);
                asfph_pkg::PH_PAD:
                  phase_d = asfph_pkg::PH_STIME;
                asfph_pkg::PH_STIME: begin
                  stime_d = acc_new;
                  phase_d = asfph_pkg::PH_DUR;
                end
                asfph_pkg::PH_DUR: begin
                  dur_d   = acc_new[15:0];
                  phase_d = asfph_pkg::PH_PCOUNT;
                end
                asfph_pkg::PH_PCOUNT: begin
                  if (pfb_q[0]) begin
                    pl_d    = acc_new[5:0];
                    phase_d = asfph_pkg::PH_PFLAGS;
                  end else begin
                    pl_d    = asfph_pkg::SinglePay;
                    cpf_d   = acc_new[7:0];
                    phase_d = asfph_pkg::PH_MOBJ;
                  end
                end
                asfph_pkg::PH_PFLAGS: begin
                  cpf_d   = acc_new[7:0];
                  phase_d = (pl_q == 6'd0) ? asfph_pkg::PH_DONE : asfph_pkg::PH_MOBJ;
                end
                asfph_pkg::PH_MOBJ:
                  phase_d = asfph_pkg::PH_MOFF;
                asfph_pkg::PH_MOFF: begin
                  if (key_hit) begin
                    key_d   = 1'b1;
                    phase_d = asfph_pkg::PH_DONE;
                  end else begin
                    phase_d = asfph_pkg::PH_REPLEN;
                  end
                end
                asfph_pkg::PH_REPLEN: begin
                  if (acc_new == 32'd0) begin
                    phase_d = asfph_pkg::PH_PAYLEN;
                  end else begin
                    // skip phase keeps the finished field bytes
                    skip_d  = {8'd0, acc_new[7:0]};
                    cnt_d   = cnt_new;
                    acc_d   = acc_new;
                    phase_d = asfph_pkg::PH_REPSKIP;
                  end
                end
                asfph_pkg::PH_PAYLEN: begin
                  if (acc_new == 32'd0) begin
                    pl_d    = pl_dec;
                    phase_d = (pl_dec != 6'd0) ? asfph_pkg::PH_PFLAGS : asfph_pkg::PH_DONE;
                  end else begin
                    skip_d  = acc_new[15:0];
                    cnt_d   = cnt_new;
                    acc_d   = acc_new;
                    phase_d = asfph_pkg::PH_PAYSKIP;
                  end
                end
                default: begin
                end
              endcase
            end
          end
          default: phase_d = asfph_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // result for the byte that ends a parse
  always_comb begin
    res_o.done = 1'b0;
    if (step && !req_i.start_of_packet) begin
      if (phase_q == asfph_pkg::PH_PAYSKIP) begin
        res_o.done = (skip_dec == 16'd0) && (pl_dec == 6'd0);
      end else if (field_complete) begin
        case (phase_q)
          asfph_pkg::PH_PFLAGS: res_o.done = (pl_q == 6'd0);
          asfph_pkg::PH_MOFF:   res_o.done = key_hit;
          asfph_pkg::PH_PAYLEN: res_o.done = (acc_new == 32'd0) && (pl_dec == 6'd0);
          default:              res_o.done = 1'b0;
        endcase
      end
    end
    res_o.res.send_time  = stime_q;
    res_o.res.duration   = dur_q;
    res_o.res.key_frame  = key_q | (phase_q == asfph_pkg::PH_MOFF && key_hit);
    res_o.res.header_bad = err_q;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vstream_q <= 7'd0;
    end else if (cfg_wr_en_i) begin
      vstream_q <= cfg_wr_data_i;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= asfph_pkg::PH_IDLE;
      cnt_q   <= 3'd0;
      acc_q   <= 32'd0;
      skip_q  <= 16'd0;
      pl_q    <= 6'd0;
      pfb_q   <= 8'd0;
      cpf_q   <= 8'd0;
      stime_q <= 32'd0;
      dur_q   <= 16'd0;
      err_q   <= 1'b0;
      key_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      skip_q  <= skip_d;
      pl_q    <= pl_d;
      pfb_q   <= pfb_d;
      cpf_q   <= cpf_d;
      stime_q <= stime_d;
      dur_q   <= dur_d;
      err_q   <= err_d;
      key_q   <= key_d;
    end
  end

endmodule

FILE: rtl/asfph_out_stage.sv
// result register toward the output channel
module asfph_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asfph_pkg::res_req_t res_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         out_send_time_o,
  output logic [15:0]         out_duration_o,
  output logic                out_key_frame_o,
  output logic                out_header_bad_o
);

  logic               valid_q, valid_d;
  asfph_pkg::result_t res_q;
  logic               push;

  // free when empty or the held request leaves this cycle
  assign ready_o = ~valid_q | ~out_stall_i;
  assign push    = res_i.done & ready_o;
  assign valid_d = push | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res_i.res;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_send_time_o  = res_q.send_time;
  assign out_duration_o   = res_q.duration;
  assign out_key_frame_o  = res_q.key_frame;
  assign out_header_bad_o = res_q.header_bad;

endmodule

FILE: rtl/asfph_checker.sv
// port-level checks of the header parser and their binding
`include "asf_packet_header_parser_defines.svh"

module asfph_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        in_start_of_packet_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_send_time_o,
  input logic [15:0] out_duration_o,
  input logic        out_key_frame_o,
  input logic        out_header_bad_o
);

  logic [49:0] res_bits;
  logic        res_held;
  logic        in_take;

  // result payload and handshake terms
  assign res_bits = {out_send_time_o, out_duration_o, out_key_frame_o, out_header_bad_o};
  assign res_held = out_valid_o && out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o && !in_start_of_packet_i;

  // a held result stays put
  `ASFPH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, res_held, out_valid_o && $stable(res_bits))

  // input stalls only behind a full, held result
  `ASFPH_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, res_held)

  // a fresh result comes from a non-start byte taken earlier, via the input and result registers
  `ASFPH_ASSERT_IMPL(a_res_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_take, 2))

endmodule

bind asf_packet_header_parser asfph_checker u_asfph_checker (.*);
